// ----- src/mpv_pkg.sv -----
// ----------------------------------------------------------------------------
// mpv_pkg
// shared types and constants for the mesh pressure-volume force core
// ----------------------------------------------------------------------------
package mpv_pkg;

    localparam int VERTS = 1024;
    localparam int AW    = $clog2(VERTS);

    localparam int DIV_W     = 80;
    localparam int DIV_DIGIT = 8;
    localparam int DIV_STEPS = DIV_W / DIV_DIGIT;

    typedef logic [AW-1:0] addr_t;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_LOAD  = 2'd1,
        FN_TRI   = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TRI_RB,
        S_TRI_RC,
        S_TRI_CAP,
        S_TRI_MUL,
        S_TRI_DOT,
        S_TRI_VOL,
        S_G_RD,
        S_G_WR,
        S_RD_CAP,
        S_F_MUL,
        S_F_DIV,
        S_F_WAIT,
        S_W_DIFF,
        S_W_MLO,
        S_W_MHI,
        S_W_DIV,
        S_W_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
    } pos_t;

    typedef struct packed {
        logic signed [39:0] gx;
        logic signed [39:0] gy;
        logic signed [39:0] gz;
    } grad_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- src/mpv_cmd_if.sv -----
// ----------------------------------------------------------------------------
// mpv_cmd_if
// request channel carrying one command and its operands
// ----------------------------------------------------------------------------
interface mpv_cmd_if import mpv_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [9:0]         vertex_index;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] cur_z;
    logic signed [15:0] old_x;
    logic signed [15:0] old_y;
    logic signed [15:0] old_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;

    modport source (
        output valid, func, vertex_index, cur_x, cur_y, cur_z,
        output old_x, old_y, old_z, corner_a, corner_b, corner_c,
        input  ready
    );

    modport sink (
        input  valid, func, vertex_index, cur_x, cur_y, cur_z,
        input  old_x, old_y, old_z, corner_a, corner_b, corner_c,
        output ready
    );

endinterface

// ----- src/mpv_res_if.sv -----
// ----------------------------------------------------------------------------
// mpv_res_if
// result channel carrying force and work of one read
// ----------------------------------------------------------------------------
interface mpv_res_if import mpv_pkg::*; ();

    logic               valid;
    logic               ready;
    logic signed [55:0] force_x;
    logic signed [55:0] force_y;
    logic signed [55:0] force_z;
    logic signed [63:0] work;

    modport source (
        output valid, force_x, force_y, force_z, work,
        input  ready
    );

    modport sink (
        input  valid, force_x, force_y, force_z, work,
        output ready
    );

endinterface

// ----- src/mpv_div6.sv -----
// ----------------------------------------------------------------------------
// mpv_div6
// iterative unsigned divide by six, one byte of quotient per cycle
// ----------------------------------------------------------------------------
module mpv_div6 import mpv_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [DIV_W-1:0] dividend,
    output div_status_t      status,
    output logic [DIV_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_STEPS);

    logic [DIV_W-1:0] sh_reg;
    logic [1:0]       rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_DIGIT-1:0] qbits;
    logic [1:0]           rem_next;

    // divide by two is the shift at start, then a radix-2 pass by three
    always_comb
    begin
        logic [2:0] r;
        r = {1'b0, rem_reg};
        qbits = '0;
        for (int i = 0; i < DIV_DIGIT; i++)
        begin
            r = {r[1:0], sh_reg[DIV_W-1-i]};
            if (r >= 3'd3)
            begin
                qbits[DIV_DIGIT-1-i] = 1'b1;
                r = r - 3'd3;
            end
        end
        rem_next = r[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sh_reg  <= dividend >> 1;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DIV_W-DIV_DIGIT-1:0], qbits};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = sh_reg;

endmodule

// ----- src/mesh_pressure_volume_force_core.sv -----
// ----------------------------------------------------------------------------
// mesh_pressure_volume_force_core
// pressure force and pressure-volume work over a closed triangle mesh
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | contents
//  cmd     | in  | valid/ready   | func, vertex index, positions, corners
//  res     | out | valid/ready   | force_x/y/z, work (read requests only)
//  cfg     | in  | cfg_we        | pressure, signed q16.0
//
//  start and load requests, and triangles with a corner out of range, finish
//  as they are taken; a triangle steps through three position reads, cross
//  and dot products and three accumulator read-modify-writes on the gradient
//  memory; a read makes four passes of the shared divide-by-six unit
//  reset clears control, volume sums and pressure; memories hold no reset
//  a finished result waits in the output register while the next request
//  is taken; the core stalls only when a second result meets a full one
// ----------------------------------------------------------------------------
module mesh_pressure_volume_force_core import mpv_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    mpv_cmd_if.sink            cmd,
    mpv_res_if.source          res,
    input  logic               cfg_we,
    input  logic signed [15:0] cfg_data
);

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } vec33_t;

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    function automatic logic signed [32:0] xterm(
        input logic signed [15:0] a, input logic signed [15:0] b,
        input logic signed [15:0] c, input logic signed [15:0] d);
        logic signed [32:0] t1;
        logic signed [32:0] t2;
        t1 = a * b;
        t2 = c * d;
        return t1 - t2;
    endfunction

    function automatic vec33_t cross3(
        input logic signed [15:0] ux, input logic signed [15:0] uy,
        input logic signed [15:0] uz, input logic signed [15:0] vx,
        input logic signed [15:0] vy, input logic signed [15:0] vz);
        vec33_t r;
        r.x = xterm(uy, vz, uz, vy);
        r.y = xterm(uz, vx, ux, vz);
        r.z = xterm(ux, vy, uy, vx);
        return r;
    endfunction

    function automatic logic signed [50:0] dot(
        input logic signed [15:0] ux, input logic signed [15:0] uy,
        input logic signed [15:0] uz, input vec33_t w);
        logic signed [50:0] p0;
        logic signed [50:0] p1;
        logic signed [50:0] p2;
        p0 = ux * w.x;
        p1 = uy * w.y;
        p2 = uz * w.z;
        return p0 + p1 + p2;
    endfunction

    function automatic logic signed [39:0] sat40(
        input logic signed [39:0] acc, input logic signed [32:0] d);
        logic signed [40:0] s;
        s = acc + d;
        if (s > 41'sh0_7FFF_FFFF_FF)
            return {1'b0, {39{1'b1}}};
        else if (s < -41'sh0_8000_0000_00)
            return {1'b1, {39{1'b0}}};
        else
            return s[39:0];
    endfunction

    function automatic logic signed [63:0] sat64(
        input logic signed [63:0] acc, input logic signed [50:0] d);
        logic signed [64:0] s;
        s = acc + d;
        if (s[64] != s[63])
            return s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        else
            return s[63:0];
    endfunction

    function automatic logic idx_ok(input logic [9:0] i);
        return 32'(i) < VERTS;
    endfunction

    // ------------------------------------------------------------------
    // memories: positions and gradient sums, registered read data
    // ------------------------------------------------------------------
    pos_t  pos_mem  [VERTS];
    grad_t gsum_mem [VERTS];

    pos_t  pos_q;
    grad_t gsum_q;
    addr_t pos_raddr;
    addr_t gsum_raddr;
    addr_t gsum_waddr;
    addr_t pos_waddr;
    grad_t gsum_wdata;
    pos_t  pos_wdata;
    logic  pos_we;
    logic  gsum_we;

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_q <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gsum_we)
            gsum_mem[gsum_waddr] <= gsum_wdata;
        gsum_q <= gsum_mem[gsum_raddr];
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic signed [15:0] pressure_reg;
    logic signed [63:0] vol_reg;
    logic signed [63:0] old_vol_reg;

    addr_t              corner_reg [3];
    logic [1:0]         k_reg;
    pos_t               pa_reg, pb_reg;
    vec33_t             ga_reg, gb_reg, gc_reg, po_reg;
    logic signed [50:0] dcur_reg, dold_reg;

    grad_t              g_reg;
    logic               vi_ok_reg;
    logic signed [55:0] prod_reg;
    logic               fneg_reg;
    logic signed [55:0] f_reg [3];

    logic [63:0]        wmag_reg;
    logic               wneg_reg;
    logic [15:0]        pm_reg;
    logic [DIV_W-1:0]   wprod_reg;
    logic signed [63:0] work_reg;

    logic               res_valid_reg;
    logic signed [55:0] res_fx_reg, res_fy_reg, res_fz_reg;
    logic signed [63:0] res_work_reg;

    logic               res_load;
    logic               cmd_ready;
    logic               cmd_take;

    div_ctrl_t          div_ctrl;
    div_status_t        div_st;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_q;

    vec33_t             grad_sel;
    logic signed [39:0] g_axis;
    logic [55:0]        prod_mag;

    assign cmd_take = cmd.valid && cmd_ready;
    assign cmd.ready = cmd_ready;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    grad_sel = ga_reg;
            2'd1:    grad_sel = gb_reg;
            default: grad_sel = gc_reg;
        endcase
        unique case (k_reg)
            2'd0:    g_axis = g_reg.gx;
            2'd1:    g_axis = g_reg.gy;
            default: g_axis = g_reg.gz;
        endcase
        prod_mag = prod_reg[55] ? 56'(-prod_reg) : 56'(prod_reg);
    end

    mpv_div6 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .status   (div_st),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // sequencer: next state and control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_ready      = 1'b0;
        pos_raddr      = corner_reg[1];
        pos_waddr      = AW'(cmd.vertex_index);
        pos_wdata      = {cmd.cur_x, cmd.cur_y, cmd.cur_z,
                          cmd.old_x, cmd.old_y, cmd.old_z};
        pos_we         = 1'b0;
        gsum_raddr     = corner_reg[k_reg];
        gsum_waddr     = corner_reg[k_reg];
        gsum_wdata     = '{gx: sat40(gsum_q.gx, grad_sel.x),
                           gy: sat40(gsum_q.gy, grad_sel.y),
                           gz: sat40(gsum_q.gz, grad_sel.z)};
        gsum_we        = 1'b0;
        div_ctrl.start = 1'b0;
        div_dividend   = DIV_W'(prod_mag);
        res_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready  = 1'b1;
                pos_raddr  = AW'(cmd.corner_a);
                gsum_raddr = AW'(cmd.vertex_index);
                if (cmd.valid)
                begin
                    unique case (func_t'(cmd.func))
                        FN_START: ;
                        FN_LOAD:
                        begin
                            if (idx_ok(cmd.vertex_index))
                            begin
                                pos_we     = 1'b1;
                                gsum_we    = 1'b1;
                                gsum_waddr = AW'(cmd.vertex_index);
                                gsum_wdata = '0;
                            end
                        end
                        FN_TRI:
                        begin
                            if (idx_ok(cmd.corner_a) && idx_ok(cmd.corner_b) &&
                                idx_ok(cmd.corner_c))
                                state_next = S_TRI_RB;
                        end
                        FN_READ: state_next = S_RD_CAP;
                    endcase
                end
            end
            S_TRI_RB:
            begin
                pos_raddr  = corner_reg[1];
                state_next = S_TRI_RC;
            end
            S_TRI_RC:
            begin
                pos_raddr  = corner_reg[2];
                state_next = S_TRI_CAP;
            end
            S_TRI_CAP:
            begin
                // keep corner c on the read port for the product cycle
                pos_raddr  = corner_reg[2];
                state_next = S_TRI_MUL;
            end
            S_TRI_MUL: state_next = S_TRI_DOT;
            S_TRI_DOT: state_next = S_TRI_VOL;
            S_TRI_VOL: state_next = S_G_RD;
            S_G_RD:    state_next = S_G_WR;
            S_G_WR:
            begin
                gsum_we    = 1'b1;
                state_next = (k_reg == 2'd2) ? S_IDLE : S_G_RD;
            end
            S_RD_CAP:  state_next = S_F_MUL;
            S_F_MUL:   state_next = S_F_DIV;
            S_F_DIV:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_F_WAIT;
            end
            S_F_WAIT:
            begin
                if (div_st.done)
                    state_next = (k_reg == 2'd2) ? S_W_DIFF : S_F_MUL;
            end
            S_W_DIFF:  state_next = S_W_MLO;
            S_W_MLO:   state_next = S_W_MHI;
            S_W_MHI:   state_next = S_W_DIV;
            S_W_DIV:
            begin
                div_ctrl.start = 1'b1;
                div_dividend   = wprod_reg;
                state_next     = S_W_WAIT;
            end
            S_W_WAIT:
            begin
                if (div_st.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // pressure register and volume sums
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_reg <= '0;
            vol_reg      <= '0;
            old_vol_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                pressure_reg <= cfg_data;
            if (cmd_take && func_t'(cmd.func) == FN_START)
            begin
                vol_reg     <= '0;
                old_vol_reg <= '0;
            end
            else if (state_reg == S_TRI_VOL)
            begin
                vol_reg     <= sat64(vol_reg, dcur_reg);
                old_vol_reg <= sat64(old_vol_reg, dold_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        logic signed [64:0] diff;
        logic [63:0]        lim;
        logic [63:0]        m;
        logic signed [55:0] fq;
        logic [47:0]        wmul;

        diff = 65'(old_vol_reg) - 65'(vol_reg);
        lim  = wneg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        m    = (div_q > DIV_W'(lim)) ? lim : div_q[63:0];
        fq   = div_q[55:0];
        // one 16 x 32 partial product per cycle
        wmul = pm_reg * ((state_reg == S_W_MLO) ? wmag_reg[31:0] : wmag_reg[63:32]);

        unique case (state_reg)
            S_IDLE:
            begin
                corner_reg[0] <= AW'(cmd.corner_a);
                corner_reg[1] <= AW'(cmd.corner_b);
                corner_reg[2] <= AW'(cmd.corner_c);
                vi_ok_reg     <= idx_ok(cmd.vertex_index);
                k_reg         <= '0;
            end
            S_TRI_RB:  pa_reg <= pos_q;
            S_TRI_RC:  pb_reg <= pos_q;
            S_TRI_MUL:
            begin
                // corner c arrives now; gradients from current, one from previous
                ga_reg <= cross3(pb_reg.cx, pb_reg.cy, pb_reg.cz,
                                 pos_q.cx, pos_q.cy, pos_q.cz);
                gb_reg <= cross3(pos_q.cx, pos_q.cy, pos_q.cz,
                                 pa_reg.cx, pa_reg.cy, pa_reg.cz);
                gc_reg <= cross3(pa_reg.cx, pa_reg.cy, pa_reg.cz,
                                 pb_reg.cx, pb_reg.cy, pb_reg.cz);
                po_reg <= cross3(pb_reg.ox, pb_reg.oy, pb_reg.oz,
                                 pos_q.ox, pos_q.oy, pos_q.oz);
            end
            S_TRI_DOT:
            begin
                dcur_reg <= dot(pa_reg.cx, pa_reg.cy, pa_reg.cz, ga_reg);
                dold_reg <= dot(pa_reg.ox, pa_reg.oy, pa_reg.oz, po_reg);
            end
            S_G_WR: k_reg <= k_reg + 2'd1;
            S_RD_CAP:
            begin
                g_reg <= gsum_q;
                k_reg <= '0;
            end
            S_F_MUL: prod_reg <= pressure_reg * g_axis;
            S_F_DIV: fneg_reg <= prod_reg[55];
            S_F_WAIT:
            begin
                if (div_st.done)
                begin
                    // truncation toward zero, sign flipped
                    f_reg[k_reg] <= !vi_ok_reg ? '0 : (fneg_reg ? fq : -fq);
                    k_reg        <= k_reg + 2'd1;
                end
            end
            S_W_DIFF:
            begin
                wmag_reg <= diff[64] ? 64'(-diff) : 64'(diff);
                wneg_reg <= diff[64] ^ pressure_reg[15];
                pm_reg   <= pressure_reg[15] ? 16'(-pressure_reg) : 16'(pressure_reg);
            end
            S_W_MLO: wprod_reg <= DIV_W'(wmul);
            S_W_MHI: wprod_reg <= wprod_reg + {wmul, 32'd0};
            S_W_WAIT:
            begin
                if (div_st.done)
                    work_reg <= wneg_reg ? -m : m;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_fx_reg   <= f_reg[0];
            res_fy_reg   <= f_reg[1];
            res_fz_reg   <= f_reg[2];
            res_work_reg <= work_reg;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.force_x = res_fx_reg;
    assign res.force_y = res_fy_reg;
    assign res.force_z = res_fz_reg;
    assign res.work    = res_work_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !div_st.busy)
        else $error("divider busy while idle");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |=> div_st.busy)
        else $error("divider did not start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || res.ready))
        else $error("pending result overwritten");

endmodule

// ----- tb/sv/mesh_pressure_volume_force_core_tb.sv -----
// ----------------------------------------------------------------------------
// mesh_pressure_volume_force_core_tb
// Self-checking bench for the mesh pressure-volume force core. A short
// directed table covers the coordinate and pressure extremes, repeated
// corners and the zero-pressure and cleared-sum cases. A long random run of
// mesh builds, triangles and reads follows under several pressure settings.
// Every read result is checked against a local predictor of the core, or against a result given in its directed row.
// ----------------------------------------------------------------------------
module mesh_pressure_volume_force_core_tb;
    import mpv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RAND_ITEMS = 800;
    localparam int  SETTLE     = 30;     // covers a trailing triangle
    localparam int  IDLE_LIMIT = 4000;   // cycles with no request moving at all
    localparam int  LONG_HOLD  = 400;

    // one command request
    typedef struct packed {
        func_t fn;
        addr_t vi;
        pos_t  p;
        addr_t ca;
        addr_t cb;
        addr_t cc;
    } cmd_t;

    // one read result
    typedef struct packed {
        logic signed [55:0] fx;
        logic signed [55:0] fy;
        logic signed [55:0] fz;
        logic signed [63:0] work;
    } force_t;

    // row of the directed table: a pressure write or a command
    typedef struct packed {
        bit                 is_cfg;
        logic signed [15:0] pval;
        cmd_t               c;
        bit                 typed;   // expected result given in the row
        force_t             want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic signed [15:0] cfg_data = '0;

    mpv_cmd_if cmd_ch ();
    mpv_res_if res_ch ();

    mesh_pressure_volume_force_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .res      (res_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: positions, gradient sums, volume sums, pressure
    // ------------------------------------------------------------------
    pos_t               pos_mem [VERTS];
    grad_t              grad_mem [VERTS];
    logic signed [63:0] vol_acc;
    logic signed [63:0] old_vol_acc;
    logic signed [15:0] press;
    bit                 loaded [VERTS];
    addr_t              live [$];        // vertices loaded so far

    force_t pending_forces [$];          // reads accepted, result not yet seen

    int  errors = 0;
    bit  quiet = 1'b0;                   // both sides run with no idling
    bit  long_hold = 1'b0;               // receiver to hold off for a long stretch
    int  idle_cycles = 0;

    // saturating adds at the accumulator widths
    function automatic logic signed [39:0] sat40(logic signed [39:0] a, longint d);
        logic signed [127:0] s;
        s = a + d;
        if (s > 128'sd549755813887)
            return 40'sh7f_ffff_ffff;
        if (s < -128'sd549755813888)
            return 40'sh80_0000_0000;
        return s[39:0];
    endfunction

    function automatic logic signed [63:0] sat64(logic signed [63:0] a, longint d);
        logic signed [127:0] s;
        s = a + d;
        if (s > 128'sh7fff_ffff_ffff_ffff)
            return 64'sh7fff_ffff_ffff_ffff;
        if (s < -128'sh8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // r = u x v, components as longints
    function automatic void cross3(input longint ux, uy, uz, vx, vy, vz,
                                   output longint rx, ry, rz);
        rx = uy * vz - uz * vy;
        ry = uz * vx - ux * vz;
        rz = ux * vy - uy * vx;
    endfunction

    // work = pressure * (old volume - volume) / 6, exact, saturated
    function automatic logic signed [63:0] work_now();
        logic signed [127:0] d;
        logic signed [127:0] q;
        d = old_vol_acc - vol_acc;
        q = (d * press) / 6;
        if (q > 128'sh7fff_ffff_ffff_ffff)
            return 64'sh7fff_ffff_ffff_ffff;
        if (q < -128'sh8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return q[63:0];
    endfunction

    function automatic logic signed [55:0] force_of(logic signed [39:0] g);
        longint f;
        f = -(longint'(press) * longint'(g)) / 6;
        return f[55:0];
    endfunction

    // advance the predictor by one accepted command; 1 when a result follows
    function automatic bit mesh_predict(cmd_t c, output force_t r);
        longint ga[3], gb[3], gc[3], pc[3];
        pos_t   a, b, k;
        r = '0;
        case (c.fn)
            FN_START:
            begin
                vol_acc     = '0;
                old_vol_acc = '0;
            end
            FN_LOAD:
            begin
                pos_mem[c.vi]  = c.p;
                grad_mem[c.vi] = '0;
                if (!loaded[c.vi])
                    live.push_back(c.vi);
                loaded[c.vi] = 1'b1;
            end
            FN_TRI:
            begin
                a = pos_mem[c.ca];
                b = pos_mem[c.cb];
                k = pos_mem[c.cc];
                // gradients are all taken from positions before any add
                cross3(b.cx, b.cy, b.cz, k.cx, k.cy, k.cz, ga[0], ga[1], ga[2]);
                cross3(k.cx, k.cy, k.cz, a.cx, a.cy, a.cz, gb[0], gb[1], gb[2]);
                cross3(a.cx, a.cy, a.cz, b.cx, b.cy, b.cz, gc[0], gc[1], gc[2]);
                cross3(b.ox, b.oy, b.oz, k.ox, k.oy, k.oz, pc[0], pc[1], pc[2]);
                vol_acc = sat64(vol_acc, a.cx * ga[0] + a.cy * ga[1] + a.cz * ga[2]);
                old_vol_acc = sat64(old_vol_acc,
                                    a.ox * pc[0] + a.oy * pc[1] + a.oz * pc[2]);
                grad_mem[c.ca].gx = sat40(grad_mem[c.ca].gx, ga[0]);
                grad_mem[c.ca].gy = sat40(grad_mem[c.ca].gy, ga[1]);
                grad_mem[c.ca].gz = sat40(grad_mem[c.ca].gz, ga[2]);
                grad_mem[c.cb].gx = sat40(grad_mem[c.cb].gx, gb[0]);
                grad_mem[c.cb].gy = sat40(grad_mem[c.cb].gy, gb[1]);
                grad_mem[c.cb].gz = sat40(grad_mem[c.cb].gz, gb[2]);
                grad_mem[c.cc].gx = sat40(grad_mem[c.cc].gx, gc[0]);
                grad_mem[c.cc].gy = sat40(grad_mem[c.cc].gy, gc[1]);
                grad_mem[c.cc].gz = sat40(grad_mem[c.cc].gz, gc[2]);
            end
            default:
            begin
                r.fx   = force_of(grad_mem[c.vi].gx);
                r.fy   = force_of(grad_mem[c.vi].gy);
                r.fz   = force_of(grad_mem[c.vi].gz);
                r.work = work_now();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // present one request and hold it until the core takes it
    task automatic send_cmd(cmd_t c, bit typed, force_t want);
        force_t r;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= c.fn;
        cmd_ch.vertex_index <= c.vi;
        cmd_ch.cur_x        <= c.p.cx;
        cmd_ch.cur_y        <= c.p.cy;
        cmd_ch.cur_z        <= c.p.cz;
        cmd_ch.old_x        <= c.p.ox;
        cmd_ch.old_y        <= c.p.oy;
        cmd_ch.old_z        <= c.p.oz;
        cmd_ch.corner_a     <= c.ca;
        cmd_ch.corner_b     <= c.cb;
        cmd_ch.corner_c     <= c.cc;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (mesh_predict(c, r))
            pending_forces.push_back(typed ? want : r);
    endtask

    // random gap before the next request; valid drops only when there is one
    task automatic sender_gap();
        int n;
        n = quiet ? 0 : $urandom_range(0, 12);
        if (n > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop offering requests until every read has answered and the core is idle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pressure(logic signed [15:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        press = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 4095)) - 16'sd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed mesh traffic: corners and reads only on loaded vertices
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   pick;
        c.fn = FN_START;
        c.vi = addr_t'($urandom);
        c.p  = {rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord()};
        c.ca = addr_t'($urandom);
        c.cb = addr_t'($urandom);
        c.cc = addr_t'($urandom);
        pick = (live.size() < 3) ? 0 : $urandom_range(0, 99);
        if (pick < 22)
            c.fn = FN_LOAD;
        else if (pick < 67)
        begin
            c.fn = FN_TRI;
            c.ca = live[$urandom_range(0, live.size() - 1)];
            c.cb = live[$urandom_range(0, live.size() - 1)];
            c.cc = live[$urandom_range(0, live.size() - 1)];
        end
        else if (pick < 95)
        begin
            c.fn = FN_READ;
            c.vi = live[$urandom_range(0, live.size() - 1)];
        end
        return c;
    endfunction

    function automatic row_t cfg_row(logic signed [15:0] v);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.pval   = v;
        return r;
    endfunction

    function automatic row_t cmd_row(func_t fn, addr_t vi, pos_t p,
                                     addr_t ca, addr_t cb, addr_t cc, bit typed);
        row_t r;
        r       = '0;
        r.c     = '{fn: fn, vi: vi, p: p, ca: ca, cb: cb, cc: cc};
        r.typed = typed;   // typed rows all expect zero force and work
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        row_t               rows [$];
        logic signed [15:0] phase_press [5];
        cmd_t               c;
        force_t             none;

        none = '0;
        press = '0;
        vol_acc = '0;
        old_vol_acc = '0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        cmd_ch.valid = 1'b0;
        cmd_ch.func = FN_START;
        cmd_ch.vertex_index = '0;
        cmd_ch.cur_x = '0;
        cmd_ch.cur_y = '0;
        cmd_ch.cur_z = '0;
        cmd_ch.old_x = '0;
        cmd_ch.old_y = '0;
        cmd_ch.old_z = '0;
        cmd_ch.corner_a = '0;
        cmd_ch.corner_b = '0;
        cmd_ch.corner_c = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table; pressure is zero out of reset
        rows.push_back(cmd_row(FN_LOAD, 10'd0,
            {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
            '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_READ, 10'd0, '0, '0, '0, '0, 1'b1));
        rows.push_back(cmd_row(FN_LOAD, 10'd1023,
            {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff},
            '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_LOAD, 10'd682,
            {16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0},
            '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_LOAD, 10'd341,
            {16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256},
            '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_TRI, '0, '0, 10'd0, 10'd1023, 10'd682, 1'b0));
        rows.push_back(cmd_row(FN_TRI, '0, '0, 10'd682, 10'd341, 10'd1023, 1'b0));
        // repeated corners
        rows.push_back(cmd_row(FN_TRI, '0, '0, 10'd341, 10'd341, 10'd341, 1'b0));
        rows.push_back(cmd_row(FN_TRI, '0, '0, 10'd0, 10'd0, 10'd682, 1'b0));
        // zero pressure reads as zero even with sums built up
        rows.push_back(cmd_row(FN_READ, 10'd1023, '0, '0, '0, '0, 1'b1));
        rows.push_back(cfg_row(16'sh7fff));
        rows.push_back(cmd_row(FN_READ, 10'd0, '0, '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_READ, 10'd682, '0, '0, '0, '0, 1'b0));
        rows.push_back(cfg_row(16'sh8000));
        rows.push_back(cmd_row(FN_READ, 10'd341, '0, '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_READ, 10'd1023, '0, '0, '0, '0, 1'b0));
        // start clears the volumes; a fresh vertex has no gradient
        rows.push_back(cmd_row(FN_START, 10'h3ff, '0, 10'h3ff, 10'h3ff, 10'h3ff, 1'b0));
        rows.push_back(cmd_row(FN_LOAD, 10'd5,
            {16'sh1234, -16'sh0567, 16'sh0100, 16'sh0fff, 16'sh0001, -16'sh0001},
            '0, '0, '0, 1'b0));
        rows.push_back(cmd_row(FN_READ, 10'd5, '0, '0, '0, '0, 1'b1));
        rows.push_back(cfg_row(16'sd1));
        rows.push_back(cmd_row(FN_TRI, '0, '0, 10'd0, 10'd1023, 10'd682, 1'b0));
        rows.push_back(cmd_row(FN_READ, 10'd0, '0, '0, '0, '0, 1'b0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_pressure(rows[i].pval);
            else
            begin
                send_cmd(rows[i].c, rows[i].typed, rows[i].want);
                sender_gap();
            end
        end

        // random part, one pressure per phase, extremes among them
        phase_press = '{16'sh7fff, 16'sh8000, 16'sd256, 16'($urandom), 16'sd0};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_pressure(phase_press[ph]);
            for (int n = 0; n < RAND_ITEMS / 5; n++)
            begin
                // phase 1: a long receiver hold-off while requests keep coming
                if (ph == 1 && n == 10)
                    long_hold = 1'b1;
                // a pause of the sender until every result is in
                if (ph == 2 && n == 80)
                    drain();
                // a stretch with no idling on either side
                quiet = (ph == 3 && n >= 40 && n < 120);
                c = rand_cmd();
                send_cmd(c, 1'b0, none);
                sender_gap();
            end
        end
        quiet = 1'b0;

        drain();
        if (errors == 0)
            $display("PASS mesh_pressure_volume_force_core");
        else
            $display("FAIL mesh_pressure_volume_force_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                n = LONG_HOLD;
            end
            else
                n = quiet ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                res_ch.ready <= 1'b0;
                for (int i = 0; i < n; i++)
                    @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    // compare each result with the oldest outstanding read
    always @(posedge clk)
    begin
        force_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_forces.size() == 0)
            begin
                errors++;
                $display("%0t: result with no read outstanding, fx=%0d work=%0d",
                         $time, res_ch.force_x, res_ch.work);
            end
            else
            begin
                want = pending_forces.pop_front();
                if (res_ch.force_x !== want.fx)
                begin
                    errors++;
                    $display("%0t: force_x expected %0d got %0d",
                             $time, want.fx, res_ch.force_x);
                end
                if (res_ch.force_y !== want.fy)
                begin
                    errors++;
                    $display("%0t: force_y expected %0d got %0d",
                             $time, want.fy, res_ch.force_y);
                end
                if (res_ch.force_z !== want.fz)
                begin
                    errors++;
                    $display("%0t: force_z expected %0d got %0d",
                             $time, want.fz, res_ch.force_z);
                end
                if (res_ch.work !== want.work)
                begin
                    errors++;
                    $display("%0t: work expected %0d got %0d",
                             $time, want.work, res_ch.work);
                end
            end
        end
    end

    // watchdog: too long with no request moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL mesh_pressure_volume_force_core");
            $finish;
        end
    end

endmodule
